/* rtl/core/ssev_pkg.sv */
package ssev_pkg;

    localparam int SPRITE_COUNT = 128;
    localparam int SPRITE_AW = 7;
    localparam int SPRITES_PER_LINE_DEF = 32;
    localparam int TILES_PER_LINE_DEF = 34;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_EVAL    = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [1:0] OP_IGNORED = 2'd3;

    localparam logic [2:0] REG_SIZE_MODE    = 3'd0;
    localparam logic [2:0] REG_NAME_GAP     = 3'd1;
    localparam logic [2:0] REG_TILE_BASE    = 3'd2;
    localparam logic [2:0] REG_HALF_HEIGHT  = 3'd3;
    localparam logic [2:0] REG_HIRES        = 3'd4;
    localparam logic [2:0] REG_INTERLACE    = 3'd5;
    localparam logic [2:0] REG_FIRST_SPRITE = 3'd6;

    typedef struct packed {
        logic [1:0] operation;
        logic [9:0] address;
        logic [7:0] write_data;
        logic [7:0] scanline;
        logic       field;
    } t_item;

    typedef struct packed {
        logic [8:0]  tile_x;
        logic [7:0]  tile_row;
        logic [1:0]  priority_res;
        logic [7:0]  palette_base;
        logic        hflip;
        logic [10:0] tile_index;
        logic        tile_valid;
        logic        last;
        logic        sprite_ovf;
        logic        tile_ovf;
    } t_result;

    typedef struct packed {
        logic [8:0]  tile_x;
        logic [7:0]  tile_row;
        logic [1:0]  priority_res;
        logic [7:0]  palette_base;
        logic        hflip;
        logic [10:0] tile_index;
    } t_tile;

    typedef struct packed {
        logic [8:0] x;
        logic [8:0] y;
        logic [7:0] chr;
        logic       vflip;
        logic       hflip;
        logic [1:0] pri;
        logic [2:0] pal;
        logic       nsel;
        logic       big;
    } t_sprite;

    typedef struct packed {
        logic [SPRITE_AW-1:0] rd_addr;
        logic                 wr_en;
        logic [SPRITE_AW-1:0] wr_addr;
        t_sprite              wr_data;
    } t_mem_req;

    function automatic logic [6:0] sprite_w(input logic [2:0] mode, input logic big);
        logic [6:0] w;
        unique case (mode)
            3'd0: w = big ? 7'd16 : 7'd8;
            3'd1: w = big ? 7'd32 : 7'd8;
            3'd2: w = big ? 7'd64 : 7'd8;
            3'd3: w = big ? 7'd32 : 7'd16;
            3'd4: w = big ? 7'd64 : 7'd16;
            3'd5: w = big ? 7'd64 : 7'd32;
            3'd6: w = big ? 7'd32 : 7'd16;
            default: w = big ? 7'd32 : 7'd16;
        endcase
        return w;
    endfunction

    function automatic logic [6:0] sprite_h(input logic [2:0] mode, input logic big);
        logic [6:0] h;
        unique case (mode)
            3'd0: h = big ? 7'd16 : 7'd8;
            3'd1: h = big ? 7'd32 : 7'd8;
            3'd2: h = big ? 7'd64 : 7'd8;
            3'd3: h = big ? 7'd32 : 7'd16;
            3'd4: h = big ? 7'd64 : 7'd16;
            3'd5: h = big ? 7'd64 : 7'd32;
            3'd6: h = big ? 7'd64 : 7'd32;
            default: h = 7'd32;
        endcase
        return h;
    endfunction

endpackage

/* rtl/core/ssev_sprite_mem.sv */
module ssev_sprite_mem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ssev_pkg::t_mem_req i_req,
    output ssev_pkg::t_sprite  o_rd_data
);
    import ssev_pkg::*;

    t_sprite                 mem [SPRITE_COUNT];
    logic [SPRITE_COUNT-1:0] r_valid;
    t_sprite                 r_q;
    logic                    r_qv;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_q <= mem[i_req.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_qv    <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            r_qv <= r_valid[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_qv ? r_q : '0;

endmodule

/* rtl/core/sprite_scanline_evaluator_core.sv */
// An OAM byte write reads and writes back its entry; a high-table write does so for each of its
// four sprites; a clear acts at once. An evaluation scans up to 128 sprites, walks the found
// ones, loading each before its tile slots, then sends one result per cycle (at most 34).
// Throughput: one transaction at a time; start is taken only while busy is low.
// Results come out as one-cycle strobes; the receiver cannot stall.
// Reset clears the sprite table (through per-entry valid bits), configuration registers and flags.
module sprite_scanline_evaluator_core #(
    parameter int SPRITES_PER_LINE = ssev_pkg::SPRITES_PER_LINE_DEF,
    parameter int TILES_PER_LINE   = ssev_pkg::TILES_PER_LINE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ssev_pkg::t_item   i_item,
    output logic              o_result_strobe,
    output ssev_pkg::t_result o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import ssev_pkg::*;

    localparam int LIW = (SPRITES_PER_LINE > 1) ? $clog2(SPRITES_PER_LINE) : 1;
    localparam int LCW = $clog2(SPRITES_PER_LINE + 1);
    localparam int TIW = (TILES_PER_LINE > 1) ? $clog2(TILES_PER_LINE) : 1;
    localparam int TCW = $clog2(TILES_PER_LINE + 1);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_WR_RD   = 9'b000000010,
        S_WR_WB   = 9'b000000100,
        S_SCAN    = 9'b000001000,
        S_WK_ITEM = 9'b000010000,
        S_WK_SPR  = 9'b000100000,
        S_WK_LOAD = 9'b001000000,
        S_WK_TILE = 9'b010000000,
        S_EMIT    = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [2:0]  r_size_mode;
    logic [1:0]  r_name_gap;
    logic [15:0] r_tile_base;
    logic        r_half, r_hires, r_inter;
    logic [6:0]  r_first;

    logic r_rf, n_rf, r_tf, n_tf;
    logic [9:0] r_op_addr, n_op_addr;
    logic [7:0] r_op_data, n_op_data;
    logic [1:0] r_sub, n_sub;
    logic [7:0] r_line, n_line;
    logic       r_fld, n_fld;
    logic [7:0] r_s, n_s;
    logic       r_pend, n_pend;
    logic [SPRITE_AW-1:0] r_pend_n_q, n_pend_n;
    logic [LCW-1:0] r_items, n_items;
    logic [LIW-1:0] r_k, n_k;
    logic [TCW-1:0] r_tiles, n_tiles;
    logic [TCW-1:0] r_j, n_j;
    logic [2:0] r_i, n_i;

    logic [8:0]  r_sx, n_sx;
    logic [7:0]  r_row, n_row;
    logic [9:0]  r_chr, n_chr;
    logic [15:0] r_cbase, n_cbase;
    logic [2:0]  r_twm1, n_twm1;
    logic        r_hf, n_hf;
    logic [1:0]  r_pri, n_pri;
    logic [2:0]  r_pal, n_pal;

    logic r_ev, n_ev, r_etv, n_etv, r_elast, n_elast, r_erf, n_erf, r_etf, n_etf;

    logic [SPRITE_AW-1:0] li_mem [SPRITES_PER_LINE];
    logic [SPRITE_AW-1:0] r_li_q;
    logic                 li_we;
    t_tile                tb_mem [TILES_PER_LINE];
    t_tile                r_tb_q;
    logic                 tb_we;
    t_tile                tb_wdata;

    t_mem_req mem_req;
    t_sprite  sd;

    logic accept, cfg_we;
    logic [6:0] w, h, hh;
    logic       off, inr;
    logic [9:0] bottom, line10;
    logic [7:0] d, hm1, row0, rowh;
    logic [8:0] step, z;
    logic       skip;
    logic [2:0] mx;
    logic [10:0] ch11;
    logic [15:0] pos;
    logic        stop;

    ssev_sprite_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (sd)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_mode <= '0;
            r_name_gap  <= '0;
            r_tile_base <= '0;
            r_half      <= 1'b0;
            r_hires     <= 1'b0;
            r_inter     <= 1'b0;
            r_first     <= '0;
        end else if (cfg_we) begin
            case (paddr[4:2])
                REG_SIZE_MODE:    r_size_mode <= pwdata[2:0];
                REG_NAME_GAP:     r_name_gap  <= pwdata[1:0];
                REG_TILE_BASE:    r_tile_base <= pwdata[15:0];
                REG_HALF_HEIGHT:  r_half      <= pwdata[0];
                REG_HIRES:        r_hires     <= pwdata[0];
                REG_INTERLACE:    r_inter     <= pwdata[0];
                REG_FIRST_SPRITE: r_first     <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_SIZE_MODE:    prdata = {29'b0, r_size_mode};
            REG_NAME_GAP:     prdata = {30'b0, r_name_gap};
            REG_TILE_BASE:    prdata = {16'b0, r_tile_base};
            REG_HALF_HEIGHT:  prdata = {31'b0, r_half};
            REG_HIRES:        prdata = {31'b0, r_hires};
            REG_INTERLACE:    prdata = {31'b0, r_inter};
            REG_FIRST_SPRITE: prdata = {25'b0, r_first};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (li_we) begin
            li_mem[r_items[LIW-1:0]] <= r_pend_n_q;
        end
        r_li_q <= li_mem[r_k];
        if (tb_we) begin
            tb_mem[r_tiles[TIW-1:0]] <= tb_wdata;
        end
        r_tb_q <= tb_mem[r_j[TIW-1:0]];
    end

    always_comb begin
        w      = sprite_w(r_size_mode, sd.big);
        h      = sprite_h(r_size_mode, sd.big);
        hh     = r_half ? {1'b0, h[6:1]} : h;
        off    = !r_hires && (sd.x > 9'd256) && (({1'b0, sd.x} + {3'b0, w}) < 10'd512);
        bottom = {1'b0, sd.y} + {3'b0, hh};
        line10 = {2'b0, r_line};
        inr    = !off && (((line10 >= {1'b0, sd.y}) && (line10 < bottom)) ||
                 ((bottom >= 10'd256) && (r_line < bottom[7:0])));

        d    = r_line - sd.y[7:0];
        hm1  = {1'b0, h} - 8'd1;
        row0 = sd.vflip ? (hm1 - d) : d;
        rowh = r_half ? ({row0[6:0], 1'b0} + {7'b0, r_inter & r_hires & r_fld}) : row0;

        step = r_hires ? {2'b0, r_i, 4'b0} : {3'b0, r_i, 3'b0};
        z    = r_sx + step;
        skip = !r_hires && (z >= 9'd257) && (z <= 9'd504);
        mx   = r_hf ? (r_twm1 - r_i) : r_i;
        ch11 = {1'b0, r_chr} + {8'b0, mx};
        pos  = r_cbase + {ch11, 5'b0};

        tb_wdata.tile_x       = z;
        tb_wdata.tile_row     = r_row;
        tb_wdata.priority_res = r_pri;
        tb_wdata.palette_base = {1'b1, r_pal, 4'b0};
        tb_wdata.hflip        = r_hf;
        tb_wdata.tile_index   = pos[15:5];
    end

    always_comb begin
        n_state   = r_state;
        n_rf      = r_rf;
        n_tf      = r_tf;
        n_op_addr = r_op_addr;
        n_op_data = r_op_data;
        n_sub     = r_sub;
        n_line    = r_line;
        n_fld     = r_fld;
        n_s       = r_s;
        n_pend    = 1'b0;
        n_pend_n  = r_pend_n_q;
        n_items   = r_items;
        n_k       = r_k;
        n_tiles   = r_tiles;
        n_j       = r_j;
        n_i       = r_i;
        n_sx      = r_sx;
        n_row     = r_row;
        n_chr     = r_chr;
        n_cbase   = r_cbase;
        n_twm1    = r_twm1;
        n_hf      = r_hf;
        n_pri     = r_pri;
        n_pal     = r_pal;
        n_ev      = 1'b0;
        n_etv     = r_etv;
        n_elast   = r_elast;
        n_erf     = r_erf;
        n_etf     = r_etf;
        li_we     = 1'b0;
        tb_we     = 1'b0;
        stop      = 1'b0;
        mem_req         = '0;
        mem_req.wr_addr = r_op_addr[9] ? {r_op_addr[4:0], r_sub} : r_op_addr[8:2];
        mem_req.wr_data = sd;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op_addr = i_item.address;
                    n_op_data = i_item.write_data;
                    n_sub     = '0;
                    n_line    = i_item.scanline;
                    n_fld     = i_item.field;
                    n_s       = '0;
                    n_items   = '0;
                    n_tiles   = '0;
                    n_j       = '0;
                    if (i_item.operation == OP_WRITE) begin
                        n_state = S_WR_RD;
                    end else if (i_item.operation == OP_EVAL) begin
                        n_state = S_SCAN;
                    end else if (i_item.operation == OP_CLEAR) begin
                        n_rf = 1'b0;
                        n_tf = 1'b0;
                    end
                end
            end
            S_WR_RD: begin
                mem_req.rd_addr = mem_req.wr_addr;
                n_state = S_WR_WB;
            end
            S_WR_WB: begin
                mem_req.wr_en = 1'b1;
                if (!r_op_addr[9]) begin
                    unique case (r_op_addr[1:0])
                        2'd0: mem_req.wr_data.x[7:0] = r_op_data;
                        2'd1: mem_req.wr_data.y = {1'b0, r_op_data} + 9'd1;
                        2'd2: mem_req.wr_data.chr = r_op_data;
                        default: begin
                            mem_req.wr_data.vflip = r_op_data[7];
                            mem_req.wr_data.hflip = r_op_data[6];
                            mem_req.wr_data.pri   = r_op_data[5:4];
                            mem_req.wr_data.pal   = r_op_data[3:1];
                            mem_req.wr_data.nsel  = r_op_data[0];
                        end
                    endcase
                    n_state = S_IDLE;
                end else begin
                    mem_req.wr_data.x[8] = r_op_data[{r_sub, 1'b0}];
                    mem_req.wr_data.big  = r_op_data[{r_sub, 1'b1}];
                    if (r_sub == 2'd3) begin
                        n_state = S_IDLE;
                    end else begin
                        n_sub   = r_sub + 2'd1;
                        n_state = S_WR_RD;
                    end
                end
            end
            S_SCAN: begin
                mem_req.rd_addr = r_first + r_s[6:0];
                n_pend_n = mem_req.rd_addr;
                n_pend   = !r_s[7];
                if (!r_s[7]) begin
                    n_s = r_s + 8'd1;
                end
                if (r_pend && inr) begin
                    if (r_items == LCW'(SPRITES_PER_LINE)) begin
                        n_rf = 1'b1;
                        stop = 1'b1;
                    end else begin
                        li_we   = 1'b1;
                        n_items = r_items + 1'b1;
                    end
                end
                if (!r_pend && r_s[7]) begin
                    stop = 1'b1;
                end
                if (stop) begin
                    n_pend = 1'b0;
                    if (r_items == '0) begin
                        n_state = S_EMIT;
                    end else begin
                        n_k     = LIW'(r_items - 1'b1);
                        n_state = S_WK_ITEM;
                    end
                end
            end
            S_WK_ITEM: begin
                n_state = S_WK_SPR;
            end
            S_WK_SPR: begin
                mem_req.rd_addr = r_li_q;
                n_state = S_WK_LOAD;
            end
            S_WK_LOAD: begin
                n_sx    = r_hires ? {sd.x[7:0], 1'b0} : sd.x;
                n_row   = rowh;
                n_chr   = {1'b0, sd.nsel, sd.chr} + {1'b0, rowh[7:3], 4'b0};
                n_cbase = r_tile_base + {12'b0, rowh[2:0], 1'b0} +
                          (sd.nsel ? {1'b0, r_name_gap, 13'b0} : 16'b0);
                n_twm1  = w[5:3] - 3'd1;
                n_hf    = sd.hflip;
                n_pri   = sd.pri;
                n_pal   = sd.pal;
                n_i     = '0;
                n_state = S_WK_TILE;
            end
            S_WK_TILE: begin
                if (!skip && (r_tiles == TCW'(TILES_PER_LINE))) begin
                    n_tf    = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    if (!skip) begin
                        tb_we   = 1'b1;
                        n_tiles = r_tiles + 1'b1;
                    end
                    if (r_i == r_twm1) begin
                        if (r_k == '0) begin
                            n_state = S_EMIT;
                        end else begin
                            n_k     = r_k - 1'b1;
                            n_state = S_WK_ITEM;
                        end
                    end else begin
                        n_i = r_i + 3'd1;
                    end
                end
            end
            S_EMIT: begin
                n_ev  = 1'b1;
                n_erf = r_rf;
                n_etf = r_tf;
                if (r_tiles == '0) begin
                    n_etv   = 1'b0;
                    n_elast = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_etv   = 1'b1;
                    n_elast = (r_j == r_tiles - 1'b1);
                    n_j     = r_j + 1'b1;
                    if (r_j == r_tiles - 1'b1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rf    <= 1'b0;
            r_tf    <= 1'b0;
            r_pend  <= 1'b0;
            r_items <= '0;
            r_tiles <= '0;
            r_ev    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rf    <= n_rf;
            r_tf    <= n_tf;
            r_pend  <= n_pend;
            r_items <= n_items;
            r_tiles <= n_tiles;
            r_ev    <= n_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op_addr  <= n_op_addr;
        r_op_data  <= n_op_data;
        r_sub      <= n_sub;
        r_line     <= n_line;
        r_fld      <= n_fld;
        r_s        <= n_s;
        r_pend_n_q <= n_pend_n;
        r_k        <= n_k;
        r_j        <= n_j;
        r_i        <= n_i;
        r_sx       <= n_sx;
        r_row      <= n_row;
        r_chr      <= n_chr;
        r_cbase    <= n_cbase;
        r_twm1     <= n_twm1;
        r_hf       <= n_hf;
        r_pri      <= n_pri;
        r_pal      <= n_pal;
        r_etv      <= n_etv;
        r_elast    <= n_elast;
        r_erf      <= n_erf;
        r_etf      <= n_etf;
    end

    assign o_result_strobe       = r_ev;
    assign o_result.tile_x       = r_etv ? r_tb_q.tile_x : '0;
    assign o_result.tile_row     = r_etv ? r_tb_q.tile_row : '0;
    assign o_result.priority_res = r_etv ? r_tb_q.priority_res : '0;
    assign o_result.palette_base = r_etv ? r_tb_q.palette_base : '0;
    assign o_result.hflip        = r_etv ? r_tb_q.hflip : 1'b0;
    assign o_result.tile_index   = r_etv ? r_tb_q.tile_index : '0;
    assign o_result.tile_valid   = r_etv;
    assign o_result.last         = r_elast;
    assign o_result.sprite_ovf   = r_erf;
    assign o_result.tile_ovf     = r_etf;

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_result.last) |=> !o_result_strobe)
        else $error("result strobe right after the last result");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && !o_result.tile_valid) |-> o_result.last)
        else $error("empty-line result not marked last");

    a_tile_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tiles <= TCW'(TILES_PER_LINE)) && (r_items <= LCW'(SPRITES_PER_LINE)))
        else $error("tile or sprite count beyond its limit");

endmodule

/* tb/sprite_scanline_evaluator_core_tb.sv */
module sprite_scanline_evaluator_core_tb;
    import ssev_pkg::*;

    class sprite_line_scoreboard;
        t_sprite   oam [SPRITE_COUNT];
        logic [2:0]  size_mode;
        logic [1:0]  name_gap;
        logic [15:0] tile_base;
        logic        half_height;
        logic        hires;
        logic        interlace;
        logic [6:0]  first_sprite;
        logic        range_flag;
        logic        time_flag;
        t_result     pending_tiles [$];
        int          error_count;

        function new();
            foreach (oam[i]) oam[i] = '0;
            size_mode = 0; name_gap = 0; tile_base = 0; half_height = 0;
            hires = 0; interlace = 0; first_sprite = 0;
            range_flag = 0; time_flag = 0; error_count = 0;
        endfunction

        function void set_reg(int idx, logic [31:0] v);
            case (idx)
                REG_SIZE_MODE:    size_mode = v[2:0];
                REG_NAME_GAP:     name_gap = v[1:0];
                REG_TILE_BASE:    tile_base = v[15:0];
                REG_HALF_HEIGHT:  half_height = v[0];
                REG_HIRES:        hires = v[0];
                REG_INTERLACE:    interlace = v[0];
                REG_FIRST_SPRITE: first_sprite = v[6:0];
                default: ;
            endcase
        endfunction

        function void dims(logic big, output int w, output int h);
            int wt [8][2] = '{'{8,16},'{8,32},'{8,64},'{16,32},'{16,64},'{32,64},
                              '{16,32},'{16,32}};
            int ht [8][2] = '{'{8,16},'{8,32},'{8,64},'{16,32},'{16,64},'{32,64},
                              '{32,64},'{32,32}};
            w = wt[size_mode][big];
            h = ht[size_mode][big];
        endfunction

        function bit sprite_on_line(t_sprite s, int line);
            int w, h, bottom;
            dims(s.big, w, h);
            if (s.x > 256 && s.x + w < 512 && !hires) return 0;
            if (half_height) h = h >> 1;
            bottom = s.y + h;
            if (line >= s.y && line < bottom) return 1;
            if (bottom >= 256 && line < (bottom & 255)) return 1;
            return 0;
        endfunction

        function void note_item(t_item it);
            int found [$];
            int n, tiles, w, h, tw, x, row, chr, noff, z, mx, pos;
            t_sprite sp;
            t_result r;
            case (it.operation)
                OP_WRITE: begin
                    if (it.address < 512) begin
                        n = it.address >> 2;
                        case (it.address[1:0])
                            2'd0: oam[n].x[7:0] = it.write_data;
                            2'd1: oam[n].y = it.write_data + 9'd1;
                            2'd2: oam[n].chr = it.write_data;
                            default: begin
                                oam[n].vflip = it.write_data[7];
                                oam[n].hflip = it.write_data[6];
                                oam[n].pri = it.write_data[5:4];
                                oam[n].pal = it.write_data[3:1];
                                oam[n].nsel = it.write_data[0];
                            end
                        endcase
                    end else begin
                        for (int k = 0; k < 4; k++) begin
                            n = (it.address[4:0] << 2) + k;
                            oam[n].x[8] = it.write_data[2*k];
                            oam[n].big = it.write_data[2*k+1];
                        end
                    end
                end
                OP_CLEAR: begin
                    range_flag = 0;
                    time_flag = 0;
                end
                OP_EVAL: begin
                    tiles = 0;
                    for (int s = 0; s < SPRITE_COUNT; s++) begin
                        n = (s + first_sprite) & (SPRITE_COUNT - 1);
                        if (!sprite_on_line(oam[n], it.scanline)) continue;
                        if (found.size() >= SPRITES_PER_LINE_DEF) begin
                            range_flag = 1;
                            break;
                        end
                        found.push_back(n);
                    end
                    for (int k = found.size() - 1; k >= 0; k--) begin
                        sp = oam[found[k]];
                        dims(sp.big, w, h);
                        tw = w >> 3;
                        x = sp.x;
                        if (hires) x = x << 1;
                        x &= 511;
                        row = sp.vflip ? (h - 1) - (it.scanline - sp.y)
                                       : it.scanline - sp.y;
                        if (half_height) begin
                            row = row << 1;
                            if (interlace && hires) row += it.field;
                        end
                        row &= 255;
                        chr = sp.chr;
                        noff = 0;
                        if (sp.nsel) begin
                            chr += 256;
                            noff = name_gap << 13;
                        end
                        chr += (row >> 3) << 4;
                        for (int i = 0; i < tw; i++) begin
                            z = (x + (i << (hires ? 4 : 3))) & 511;
                            if (z >= 257 && z + 7 < 512 && !hires) continue;
                            if (tiles >= TILES_PER_LINE_DEF) begin
                                time_flag = 1;
                                break;
                            end
                            mx = sp.hflip ? (tw - 1) - i : i;
                            pos = tile_base + ((chr + mx) << 5) + ((row & 7) << 1) + noff;
                            r = '0;
                            r.tile_x = 9'(z);
                            r.tile_row = 8'(row);
                            r.priority_res = sp.pri;
                            r.palette_base = 8'((sp.pal << 4) + 128);
                            r.hflip = sp.hflip;
                            r.tile_index = 11'((pos >> 5) & 11'h7ff);
                            r.tile_valid = 1;
                            pending_tiles.push_back(r);
                            tiles++;
                        end
                    end
                    if (tiles == 0) begin
                        pending_tiles.push_back('0);
                        tiles = 1;
                    end
                    for (int s = pending_tiles.size() - tiles; s < pending_tiles.size(); s++)
                    begin
                        pending_tiles[s].last = (s == pending_tiles.size() - 1);
                        pending_tiles[s].sprite_ovf = range_flag;
                        pending_tiles[s].tile_ovf = time_flag;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_result got);
            t_result e;
            if (pending_tiles.size() == 0) begin
                $error("unexpected result %h", got);
                error_count++;
                return;
            end
            e = pending_tiles.pop_front();
            if (got.tile_x !== e.tile_x) begin
                $error("tile_x exp %0d got %0d", e.tile_x, got.tile_x); error_count++;
            end
            if (got.tile_row !== e.tile_row) begin
                $error("tile_row exp %0d got %0d", e.tile_row, got.tile_row); error_count++;
            end
            if (got.priority_res !== e.priority_res) begin
                $error("priority_res exp %0d got %0d", e.priority_res, got.priority_res);
                error_count++;
            end
            if (got.palette_base !== e.palette_base) begin
                $error("palette_base exp %0d got %0d", e.palette_base, got.palette_base);
                error_count++;
            end
            if (got.hflip !== e.hflip) begin
                $error("hflip exp %0d got %0d", e.hflip, got.hflip); error_count++;
            end
            if (got.tile_index !== e.tile_index) begin
                $error("tile_index exp %0d got %0d", e.tile_index, got.tile_index);
                error_count++;
            end
            if (got.tile_valid !== e.tile_valid) begin
                $error("tile_valid exp %0d got %0d", e.tile_valid, got.tile_valid);
                error_count++;
            end
            if (got.last !== e.last) begin
                $error("last exp %0d got %0d", e.last, got.last); error_count++;
            end
            if (got.sprite_ovf !== e.sprite_ovf) begin
                $error("sprite_ovf exp %0d got %0d", e.sprite_ovf, got.sprite_ovf);
                error_count++;
            end
            if (got.tile_ovf !== e.tile_ovf) begin
                $error("tile_ovf exp %0d got %0d", e.tile_ovf, got.tile_ovf);
                error_count++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_item       i_item;
    logic        o_result_strobe;
    t_result     o_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sprite_line_scoreboard board;
    int cycle_count;

    sprite_scanline_evaluator_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .o_result_strobe(o_result_strobe), .o_result(o_result), .psel(psel),
        .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe) board.check_result(o_result);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("sprite_scanline_evaluator_core_tb: errors");
            $finish;
        end
    end

    task automatic write_reg(int idx, logic [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 5'(idx * 4); pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        board.set_reg(idx, v);
    endtask

    task automatic drain();
        while (board.pending_tiles.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic send_item(t_item it);
        i_item <= it;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        board.note_item(it);
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_op(logic [1:0] op, int addr, int data, int line, int fld);
        t_item it;
        it.operation = op;
        it.address = 10'(addr);
        it.write_data = 8'(data);
        it.scanline = 8'(line);
        it.field = 1'(fld);
        send_item(it);
    endtask

    task automatic random_gap();
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    task automatic random_phase(int count);
        int line, spr;
        for (int i = 0; i < count; i++) begin
            random_gap();
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8: begin
                    spr = $urandom_range(0, 127);
                    send_op(OP_WRITE, spr * 4 + $urandom_range(0, 3), $urandom_range(0, 255),
                            0, 0);
                end
                9, 10: send_op(OP_WRITE, $urandom_range(512, 1023), $urandom_range(0, 255),
                               0, 0);
                11: send_op(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
                12: send_op(OP_IGNORED, $urandom, $urandom, $urandom, $urandom);
                default: begin
                    line = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 40);
                    send_op(OP_EVAL, $urandom, $urandom, line, $urandom_range(0, 1));
                end
            endcase
        end
    endtask

    initial begin
        board = new();
        cycle_count = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (300) @(posedge i_clk);

        // Crowd the top of the screen so that the sprite overflow flag trips.
        for (int s = 0; s < 40; s++) send_op(OP_WRITE, s * 4 + 1, 0, 0, 0);
        send_op(OP_WRITE, 512, 8'hff, 0, 0);
        send_op(OP_WRITE, 3, 8'hff, 0, 0);
        send_op(OP_WRITE, 4, 8'hff, 0, 0);
        send_op(OP_EVAL, 0, 0, 1, 0);
        send_op(OP_EVAL, 0, 0, 255, 1);
        send_op(OP_CLEAR, 0, 0, 0, 0);
        send_op(OP_IGNORED, 1023, 255, 255, 1);
        send_op(OP_EVAL, 0, 0, 5, 0);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            write_reg(REG_SIZE_MODE, phase == 0 ? 0 : (phase == 1 ? 7 : $urandom_range(0, 7)));
            write_reg(REG_NAME_GAP, phase == 1 ? 3 : $urandom_range(0, 3));
            write_reg(REG_TILE_BASE, phase == 1 ? 16'hffff : (phase == 0 ? 0 : $urandom));
            write_reg(REG_HALF_HEIGHT, phase[0]);
            write_reg(REG_HIRES, phase[1]);
            write_reg(REG_INTERLACE, phase[2] | phase[0]);
            write_reg(REG_FIRST_SPRITE, phase == 1 ? 127 : $urandom_range(0, 127));
            random_phase(phase == 3 ? 40 : 25);
            drain();
        end

        if (board.error_count == 0) begin
            $display("sprite_scanline_evaluator_core_tb: clean");
        end else begin
            $display("sprite_scanline_evaluator_core_tb: errors");
        end
        $finish;
    end
endmodule
